### rtl/cau_pkg.sv
// Complex arithmetic unit package: word types, operation and status codes.
// No dependencies; used by every module of the unit.
package cau_pkg;

  localparam int unsigned WordBits = 32;
  localparam int unsigned FracBits = 16;

  typedef enum logic [1:0] {
    OpAdd = 2'd0,
    OpSub = 2'd1,
    OpMul = 2'd2,
    OpDiv = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    StOk   = 2'd0,
    StDivZ = 2'd1,
    StSat  = 2'd2,
    StRsvd = 2'd3
  } status_e;

  typedef struct packed {
    logic [1:0]         action;
    logic signed [31:0] a_real;
    logic signed [31:0] a_imag;
    logic signed [31:0] b_real;
    logic signed [31:0] b_imag;
  } in_word_t;

  typedef struct packed {
    logic signed [31:0] res_real;
    logic signed [31:0] res_imag;
    logic [1:0]         status;
  } out_word_t;

endpackage

### rtl/cau_divstage.sv
// One restoring-division step per quotient bit, registered.
// Depends on cau_pkg (import only for house style).
module cau_divstage #(
  parameter int unsigned NumW = 128,
  parameter int unsigned DenW = 64,
  parameter int unsigned Bit  = 0
) (
  input  logic            clk_i,
  input  logic            en_i,
  input  logic [NumW-1:0] num_i,
  input  logic [DenW:0]   rem_i,
  input  logic [DenW-1:0] den_i,
  output logic [NumW-1:0] num_o,
  output logic [DenW:0]   rem_o
);
  import cau_pkg::*;

  logic [DenW+1:0] sh;
  logic [DenW+1:0] diff;
  logic [NumW-1:0] num_d;
  logic [DenW:0]   rem_d;

  always_comb begin
    sh = {rem_i, num_i[Bit]};
    diff = sh - {2'b00, den_i};
    num_d = num_i;
    if (!diff[DenW+1]) begin
      rem_d = diff[DenW:0];
      num_d[Bit] = 1'b1;
    end else begin
      rem_d = sh[DenW:0];
      num_d[Bit] = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      num_o <= num_d;
      rem_o <= rem_d;
    end
  end

endmodule

### rtl/cau_divider.sv
// Pipelined unsigned divider, one stage per quotient bit, stall-aware.
// Depends on cau_pkg and cau_divstage.
module cau_divider #(
  parameter int unsigned NumW = 128,
  parameter int unsigned DenW = 64
) (
  input  logic            clk_i,
  input  logic            en_i,
  input  logic [NumW-1:0] num_i,
  input  logic [DenW-1:0] den_i,
  output logic [NumW-1:0] quo_o
);
  import cau_pkg::*;

  logic [NumW-1:0] num_s [NumW+1];
  logic [DenW:0]   rem_s [NumW+1];
  logic [DenW-1:0] den_q [NumW+1];

  assign num_s[0] = num_i;
  assign rem_s[0] = '0;
  assign den_q[0] = den_i;

  for (genvar g = 0; g < NumW; g++) begin : g_st
    cau_divstage #(.NumW(NumW), .DenW(DenW), .Bit(NumW-1-g)) u_st (
      .clk_i (clk_i),
      .en_i  (en_i),
      .num_i (num_s[g]),
      .rem_i (rem_s[g]),
      .den_i (den_q[g]),
      .num_o (num_s[g+1]),
      .rem_o (rem_s[g+1])
    );
    always_ff @(posedge clk_i) begin
      if (en_i) den_q[g+1] <= den_q[g];
    end
  end

  assign quo_o = num_s[NumW];

endmodule

### rtl/complex_arithmetic_unit_core.sv
// Complex add/sub/mul/div unit in signed fixed point, fully pipelined.
// Depends on cau_pkg and cau_divider.
//
//  channel | signals                  | payload
//  in      | in_valid_i / in_ready_o  | cau_pkg::in_word_t  in_word_i
//  out     | out_valid_o / out_ready_i| cau_pkg::out_word_t out_word_o
//
// One word per cycle enters while the output is not stalled; a word passes the
// operand, product and sum stages, then the bit-per-stage quotient pipeline,
// before it reaches the output register. The whole pipeline advances together:
// when the output register is full and not taken, every stage holds.
// Reset clears all valid bits; data registers are not reset.
module complex_arithmetic_unit_core #(
  parameter int unsigned WORD_BITS = cau_pkg::WordBits,
  parameter int unsigned FRAC_BITS = cau_pkg::FracBits
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  cau_pkg::in_word_t  in_word_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output cau_pkg::out_word_t out_word_o
);
  import cau_pkg::*;

  localparam int unsigned W   = WORD_BITS;
  localparam int unsigned PW  = 2 * W + 1;       // sum of two products, signed
  localparam int unsigned NW  = 2 * W + FRAC_BITS; // scaled numerator magnitude
  localparam int unsigned DW  = 2 * W;           // |b|^2 magnitude
  localparam int unsigned DLat = NW;
  localparam logic [NW-1:0] QMax = NW'((65'd1 << (W - 1)) - 65'd1);

  typedef struct packed {
    logic       valid;
    op_e        op;
    logic       dz;
  } ctl_t;

  logic adv;
  logic out_valid_q;
  assign adv = !out_valid_q || out_ready_i;
  assign in_ready_o = adv;

  // stage 1: operand capture
  ctl_t s1_q;
  logic signed [W-1:0] ar_q, ai_q, br_q, bi_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) s1_q <= '0;
    else if (adv) begin
      s1_q.valid <= in_valid_i;
      s1_q.op <= op_e'(in_word_i.action);
      s1_q.dz <= 1'b0;
    end
  end
  always_ff @(posedge clk_i) begin
    if (adv) begin
      ar_q <= in_word_i.a_real[W-1:0];
      ai_q <= in_word_i.a_imag[W-1:0];
      br_q <= in_word_i.b_real[W-1:0];
      bi_q <= in_word_i.b_imag[W-1:0];
    end
  end

  // stage 2: products and add/sub
  ctl_t s2_q;
  logic signed [2*W-1:0] p_rr_q, p_ii_q, p_ri_q, p_ir_q;
  logic signed [W:0] sr_q, si_q;
  logic [2*W-1:0] bb_r_q, bb_i_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) s2_q <= '0;
    else if (adv) s2_q <= s1_q;
  end
  always_ff @(posedge clk_i) begin
    if (adv) begin
      p_rr_q <= ar_q * br_q;
      p_ii_q <= ai_q * bi_q;
      p_ri_q <= ar_q * bi_q;
      p_ir_q <= ai_q * br_q;
      bb_r_q <= (2*W)'(br_q * br_q);
      bb_i_q <= (2*W)'(bi_q * bi_q);
      if (s1_q.op == OpSub) begin
        sr_q <= (W+1)'(ar_q) - (W+1)'(br_q);
        si_q <= (W+1)'(ai_q) - (W+1)'(bi_q);
      end else begin
        sr_q <= (W+1)'(ar_q) + (W+1)'(br_q);
        si_q <= (W+1)'(ai_q) + (W+1)'(bi_q);
      end
    end
  end

  // stage 3: sums of products, denominator, numerator magnitudes
  ctl_t s3_q;
  logic signed [PW-1:0] mr_q, mi_q;
  logic [NW-1:0] nr_q, ni_q;
  logic nr_neg_q, ni_neg_q;
  logic [DW-1:0] den_q;
  logic signed [W:0] sr3_q, si3_q;
  logic signed [PW-1:0] dr_c, di_c, mr_c, mi_c;
  always_comb begin
    mr_c = PW'(p_rr_q) - PW'(p_ii_q);
    mi_c = PW'(p_ri_q) + PW'(p_ir_q);
    dr_c = PW'(p_rr_q) + PW'(p_ii_q);
    di_c = PW'(p_ir_q) - PW'(p_ri_q);
  end
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) s3_q <= '0;
    else if (adv) begin
      s3_q.valid <= s2_q.valid;
      s3_q.op <= s2_q.op;
      s3_q.dz <= (bb_r_q + bb_i_q) == '0;
    end
  end
  always_ff @(posedge clk_i) begin
    if (adv) begin
      mr_q <= mr_c;
      mi_q <= mi_c;
      sr3_q <= sr_q;
      si3_q <= si_q;
      den_q <= bb_r_q + bb_i_q;
      nr_neg_q <= dr_c[PW-1];
      ni_neg_q <= di_c[PW-1];
      nr_q <= NW'(dr_c[PW-1] ? (PW)'(-dr_c) : dr_c) << FRAC_BITS;
      ni_q <= NW'(di_c[PW-1] ? (PW)'(-di_c) : di_c) << FRAC_BITS;
    end
  end

  // quotient pipeline; side data delayed alongside
  logic [NW-1:0] qr, qi;
  logic [DW-1:0] den_use;
  assign den_use = s3_q.dz ? DW'(1) : den_q;

  cau_divider #(.NumW(NW), .DenW(DW)) u_div_r (
    .clk_i (clk_i), .en_i (adv), .num_i (nr_q), .den_i (den_use), .quo_o (qr));
  cau_divider #(.NumW(NW), .DenW(DW)) u_div_i (
    .clk_i (clk_i), .en_i (adv), .num_i (ni_q), .den_i (den_use), .quo_o (qi));

  typedef struct packed {
    ctl_t                 c;
    logic signed [PW-1:0] mr;
    logic signed [PW-1:0] mi;
    logic signed [W:0]    sr;
    logic signed [W:0]    si;
    logic                 nrn;
    logic                 nin;
  } side_t;

  side_t side_q [DLat+1];
  logic  side_v_q [DLat+1];
  assign side_q[0] = '{c: s3_q, mr: mr_q, mi: mi_q, sr: sr3_q, si: si3_q,
                       nrn: nr_neg_q, nin: ni_neg_q};
  assign side_v_q[0] = s3_q.valid;
  for (genvar g = 0; g < DLat; g++) begin : g_side
    always_ff @(posedge clk_i) begin
      if (adv) side_q[g+1] <= side_q[g];
    end
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) side_v_q[g+1] <= 1'b0;
      else if (adv) side_v_q[g+1] <= side_v_q[g];
    end
  end

  // final stage: shift, clamp, select
  side_t sd;
  assign sd = side_q[DLat];

  function automatic logic signed [W-1:0] clamp_p(input logic signed [PW-1:0] v,
                                                   output logic sat);
    logic signed [PW-1:0] sh;
    sh = v >>> FRAC_BITS;
    sat = 1'b0;
    if (sh > PW'((65'sd1 <<< (W - 1)) - 65'sd1)) begin
      sat = 1'b1;
      return {1'b0, {(W-1){1'b1}}};
    end else if (sh < -(PW'(65'sd1 <<< (W - 1)))) begin
      sat = 1'b1;
      return {1'b1, {(W-1){1'b0}}};
    end
    return sh[W-1:0];
  endfunction

  function automatic logic signed [W-1:0] clamp_s(input logic signed [W:0] v,
                                                   output logic sat);
    sat = v[W] != v[W-1];
    if (sat) return v[W] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
    return v[W-1:0];
  endfunction

  function automatic logic signed [W-1:0] clamp_q(input logic [NW-1:0] q,
                                                   input logic neg, output logic sat);
    logic [NW-1:0] lim;
    lim = neg ? QMax + NW'(1) : QMax;
    sat = q > lim;
    if (sat) return neg ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
    return neg ? W'(-q) : W'(q);
  endfunction

  logic signed [W-1:0] rr_c, ri_c;
  logic sat_r, sat_i;
  logic [1:0] st_c;
  always_comb begin
    sat_r = 1'b0;
    sat_i = 1'b0;
    rr_c = '0;
    ri_c = '0;
    case (sd.c.op)
      OpAdd, OpSub: begin
        rr_c = clamp_s(sd.sr, sat_r);
        ri_c = clamp_s(sd.si, sat_i);
      end
      OpMul: begin
        rr_c = clamp_p(sd.mr, sat_r);
        ri_c = clamp_p(sd.mi, sat_i);
      end
      default: begin
        if (!sd.c.dz) begin
          rr_c = clamp_q(qr, sd.nrn, sat_r);
          ri_c = clamp_q(qi, sd.nin, sat_i);
        end
      end
    endcase
    if (sd.c.op == OpDiv && sd.c.dz) st_c = StDivZ;
    else if (sat_r || sat_i) st_c = StSat;
    else st_c = StOk;
  end

  out_word_t out_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_valid_q <= 1'b0;
    else if (adv) out_valid_q <= side_v_q[DLat];
  end
  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_q.res_real <= 32'(rr_c);
      out_q.res_imag <= 32'(ri_c);
      out_q.status <= st_c;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o = out_q;

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_ready_i |=> out_valid_q && $stable(out_q))
    else $error("output word changed while stalled");
  a_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !adv |=> $stable(s3_q))
    else $error("pipeline moved during stall");
  a_dz: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.status == StDivZ |-> out_q.res_real == '0 && out_q.res_imag == '0)
    else $error("divide by zero gave nonzero result");

endmodule

### tb/complex_arithmetic_unit_core_tb.sv
// Testbench for complex_arithmetic_unit_core: directed and random complex add/sub/mul/div
// words checked against an in-bench fixed-point predictor. Depends on cau_pkg and the RTL.
`timescale 1ns / 100ps

module complex_arithmetic_unit_core_tb;
  import cau_pkg::*;

  localparam int unsigned LATENCY = 3 + 2 * WordBits + FracBits;
  localparam int unsigned N_RANDOM = 1800;
  localparam longint unsigned CYCLE_LIMIT = 400000;

  // Fixed-point complex arithmetic predictor; result for one input word.
  function automatic out_word_t cplx_result(in_word_t w);
    logic signed [127:0] ar, ai, br, bi, s1, s2, den, num, q, lim_hi, lim_lo;
    out_word_t r;
    logic sat;
    sat = 1'b0;
    ar = w.a_real;
    ai = w.a_imag;
    br = w.b_real;
    bi = w.b_imag;
    lim_hi = (128'sd1 <<< (WordBits - 1)) - 1;
    lim_lo = -(128'sd1 <<< (WordBits - 1));
    r.status = StOk;
    s1 = 0;
    s2 = 0;
    case (op_e'(w.action))
      OpAdd: begin
        s1 = ar + br;
        s2 = ai + bi;
      end
      OpSub: begin
        s1 = ar - br;
        s2 = ai - bi;
      end
      OpMul: begin
        s1 = (ar * br - ai * bi) >>> FracBits;
        s2 = (ar * bi + ai * br) >>> FracBits;
      end
      default: begin
        den = br * br + bi * bi;
        if (den == 0) begin
          r.status = StDivZ;
        end else begin
          num = (ar * br + ai * bi) <<< FracBits;
          q = (num < 0) ? -((-num) / den) : num / den;
          s1 = q;
          num = (ai * br - ar * bi) <<< FracBits;
          q = (num < 0) ? -((-num) / den) : num / den;
          s2 = q;
        end
      end
    endcase
    if (s1 > lim_hi) begin s1 = lim_hi; sat = 1'b1; end
    if (s1 < lim_lo) begin s1 = lim_lo; sat = 1'b1; end
    if (s2 > lim_hi) begin s2 = lim_hi; sat = 1'b1; end
    if (s2 < lim_lo) begin s2 = lim_lo; sat = 1'b1; end
    r.res_real = s1[31:0];
    r.res_imag = s2[31:0];
    if (r.status == StOk && sat) r.status = StSat;
    return r;
  endfunction

  class cau_scoreboard;
    out_word_t pending_q[$];
    int unsigned mismatches;

    function void note_input(in_word_t w);
      pending_q.push_back(cplx_result(w));
    endfunction

    function void check_output(out_word_t got);
      out_word_t exp_w;
      if (pending_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected word %h", got);
        return;
      end
      exp_w = pending_q.pop_front();
      if (got.res_real !== exp_w.res_real || got.res_imag !== exp_w.res_imag ||
          got.status !== exp_w.status) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: exp %h %h %0d got %h %h %0d", exp_w.res_real,
                   exp_w.res_imag, exp_w.status, got.res_real, got.res_imag, got.status);
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  in_word_t in_word_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  out_word_t out_word_o;

  cau_scoreboard sb = new();
  longint unsigned cycles = 0;
  bit stim_done = 1'b0;
  bit long_hold = 1'b0;

  always #5 clk_i = ~clk_i;

  complex_arithmetic_unit_core DUT (.*);

  function automatic logic [31:0] rand_operand();
    case ($urandom_range(0, 9))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'h0;
      3, 4: return $urandom_range(0, 32'h3_ffff) - 32'h2_0000;
      5: return $urandom_range(0, 32'h1ff_ffff) - 32'hff_ffff;
      default: return $urandom();
    endcase
  endfunction

  task automatic send_word(in_word_t w);
    in_valid_i <= 1'b1;
    in_word_i <= w;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_input(w);
  endtask

  task automatic idle_cycles(int unsigned n);
    in_valid_i <= 1'b0;
    repeat (n) @(posedge clk_i);
  endtask

  // Receiver: stall pattern, with one long hold-off.
  initial begin
    int unsigned phase;
    phase = 0;
    @(posedge rst_ni);
    while (1) begin
      @(posedge clk_i);
      if (out_valid_o && out_ready_i) sb.check_output(out_word_o);
      phase++;
      if (long_hold) out_ready_i <= 1'b0;
      else if (phase % 512 < 100) out_ready_i <= 1'b1;
      else out_ready_i <= ($urandom_range(0, 3) != 0) && (phase % 7 != 3);
    end
  end

  initial begin
    int unsigned hold;
    @(posedge rst_ni);
    repeat (300) @(posedge clk_i);
    long_hold = 1'b1;
    for (hold = 0; hold < 3 * LATENCY; hold++) @(posedge clk_i);
    long_hold = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("[complex_arithmetic_unit_core] ERROR");
      $finish;
    end
  end

  initial begin
    in_word_t w;
    logic [31:0] ext[4];
    int unsigned burst, k, drain;
    ext[0] = 32'h8000_0000;
    ext[1] = 32'h7fff_ffff;
    ext[2] = 32'h0;
    ext[3] = 32'hffff_ffff;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    // directed: each op on extreme operands, zero divisor
    for (int op = 0; op < 4; op++) begin
      for (int e = 0; e < 4; e++) begin
        w.action = op[1:0];
        w.a_real = ext[e];
        w.a_imag = ext[3 - e];
        w.b_real = ext[(e + 1) % 4];
        w.b_imag = ext[(e + 2) % 4];
        send_word(w);
      end
    end
    w = '{action: OpDiv, a_real: 32'h1_0000, a_imag: 32'h7fff_ffff, b_real: 0, b_imag: 0};
    send_word(w);
    w = '{action: OpDiv, a_real: 32'h7fff_ffff, a_imag: 32'h8000_0000, b_real: 1, b_imag: 0};
    send_word(w);
    w = '{action: OpMul, a_real: -1, a_imag: 0, b_real: 1, b_imag: 0};
    send_word(w);
    w = '{action: OpDiv, a_real: -1, a_imag: 0, b_real: 32'h10_0000, b_imag: 0};
    send_word(w);
    k = 0;
    while (k < N_RANDOM) begin
      burst = $urandom_range(1, 40);
      repeat (burst) begin
        w.action = 2'($urandom_range(0, 3));
        w.a_real = rand_operand();
        w.a_imag = rand_operand();
        w.b_real = rand_operand();
        w.b_imag = rand_operand();
        if (w.action == OpDiv && $urandom_range(0, 15) == 0) begin
          w.b_real = 0;
          w.b_imag = 0;
        end
        send_word(w);
        k++;
      end
      if ($urandom_range(0, 2) != 0) idle_cycles($urandom_range(1, 12));
    end
    in_valid_i <= 1'b0;
    while (sb.pending_q.size() != 0) @(posedge clk_i);
    drain = 0;
    while (drain < LATENCY + 10) begin
      @(posedge clk_i);
      drain++;
    end
    if (sb.mismatches == 0) begin
      $display("[complex_arithmetic_unit_core] OK");
    end else begin
      $display("[complex_arithmetic_unit_core] ERROR");
    end
    $finish;
  end

endmodule
